@@ rtl/dpr_pkg.sv @@
// Package with the types, constants and address decode of the dimming profile register bank.
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

  localparam int CHANNELS = 2;
  localparam int PORTS    = 2;
  localparam int PortW    = (PORTS > 1) ? $clog2(PORTS) : 1;

  localparam int NumBytes = 7;
  localparam int NumWords = 5;
  localparam int NumTools = 5;
  localparam int SlotIdxW = 3;

  localparam logic [7:0]  LockOpen     = 8'h55;
  localparam logic [7:0]  LockReset    = 8'hFF;
  localparam logic [7:0]  LockAddr     = 8'd2;
  localparam logic [4:0]  MaxAddr      = 5'd30;
  localparam logic [7:0]  ModeLowMask  = 8'h03;
  localparam logic [7:0]  ModeHighMask = 8'hC0;
  localparam logic [15:0] OnTimeReset  = 16'hFFFF;

  localparam logic [4:0] LastAddrReset = 5'd30;
  localparam logic [7:0] BankIdReset   = 8'd5;
  localparam logic [7:0] BankVerReset  = 8'd2;

  typedef enum logic [2:0] {
    FUNC_READ       = 3'd0,
    FUNC_WRITE      = 3'd1,
    FUNC_SET_STATUS = 3'd2,
    FUNC_SET_LIVE   = 3'd3,
    FUNC_SET_MODE   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DENY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LAST_ADDRESS = 2'd0,
    CFG_BANK_ID      = 2'd1,
    CFG_BANK_VERSION = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    K_LAST, K_CHK, K_LOCK, K_ID, K_VER, K_STAT, K_MODE, K_BYTE,
    K_MSB, K_LSB, K_TOOL, K_LIVE_MSB, K_LIVE_LSB
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SlotIdxW-1:0] idx;
  } slot_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  bank_address;
    logic [7:0]  byte_value;
    logic [15:0] word_value;
    logic [0:0]  channel;
    logic [2:0]  port;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_e    access_status;
    logic [7:0] effective_mode;
  } result_t;

  typedef struct packed {
    logic [4:0] last_address;
    logic [7:0] bank_id;
    logic [7:0] bank_version;
  } cfg_t;

  function automatic slot_t dpr_slot(input logic [4:0] addr);
    slot_t s;
    s.idx = '0;
    case (addr)
      5'd0:  s.kind = K_LAST;
      5'd1:  s.kind = K_CHK;
      5'd2:  s.kind = K_LOCK;
      5'd3:  s.kind = K_ID;
      5'd4:  s.kind = K_VER;
      5'd5:  s.kind = K_STAT;
      5'd6:  s.kind = K_MODE;
      5'd7:  begin s.kind = K_BYTE; s.idx = 3'd0; end
      5'd8:  begin s.kind = K_MSB;  s.idx = 3'd0; end
      5'd9:  begin s.kind = K_LSB;  s.idx = 3'd0; end
      5'd10: begin s.kind = K_BYTE; s.idx = 3'd1; end
      5'd11: begin s.kind = K_BYTE; s.idx = 3'd2; end
      5'd12: begin s.kind = K_MSB;  s.idx = 3'd1; end
      5'd13: begin s.kind = K_LSB;  s.idx = 3'd1; end
      5'd14: begin s.kind = K_BYTE; s.idx = 3'd3; end
      5'd15: begin s.kind = K_MSB;  s.idx = 3'd2; end
      5'd16: begin s.kind = K_LSB;  s.idx = 3'd2; end
      5'd17: begin s.kind = K_BYTE; s.idx = 3'd4; end
      5'd18: begin s.kind = K_MSB;  s.idx = 3'd3; end
      5'd19: begin s.kind = K_LSB;  s.idx = 3'd3; end
      5'd20: begin s.kind = K_BYTE; s.idx = 3'd5; end
      5'd21: begin s.kind = K_MSB;  s.idx = 3'd4; end
      5'd22: begin s.kind = K_LSB;  s.idx = 3'd4; end
      5'd23: begin s.kind = K_BYTE; s.idx = 3'd6; end
      5'd24: begin s.kind = K_TOOL; s.idx = 3'd0; end
      5'd25: begin s.kind = K_TOOL; s.idx = 3'd1; end
      5'd26: begin s.kind = K_TOOL; s.idx = 3'd2; end
      5'd27: begin s.kind = K_TOOL; s.idx = 3'd3; end
      5'd28: begin s.kind = K_TOOL; s.idx = 3'd4; end
      5'd29: s.kind = K_LIVE_MSB;
      5'd30: s.kind = K_LIVE_LSB;
      default: s.kind = K_CHK;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dpr_if.sv @@
// Handshake interfaces for the item, result and register write channels.
`timescale 1ns / 1ps
`default_nettype none

interface dpr_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  bank_address;
  logic [7:0]  byte_value;
  logic [15:0] word_value;
  logic [0:0]  channel;
  logic [2:0]  port;

  modport source (output valid, func, bank_address, byte_value, word_value, channel, port,
                  input ready);
  modport sink (input valid, func, bank_address, byte_value, word_value, channel, port,
                output ready);
endinterface

interface dpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] access_status;
  logic [7:0] effective_mode;

  modport source (output valid, read_data, access_status, effective_mode, input ready);
  modport sink (input valid, read_data, access_status, effective_mode, output ready);
endinterface

interface dpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/dpr_in_reg.sv @@
// Input register stage that captures one item per transfer.
`timescale 1ns / 1ps
`default_nettype none

module dpr_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  dpr_in_if.sink             in_i,
  input  wire logic          advance_i,
  output dpr_pkg::item_t     item_o,
  output logic               valid_o
);
  import dpr_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d = 1'b1;
      item_d  = '{func: in_i.func, bank_address: in_i.bank_address,
                  byte_value: in_i.byte_value, word_value: in_i.word_value,
                  channel: in_i.channel, port: in_i.port};
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;
endmodule

`default_nettype wire

@@ rtl/dpr_core.sv @@
// Bank storage with the decode and update logic for one item.
`timescale 1ns / 1ps
`default_nettype none

module dpr_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dpr_pkg::item_t  item_i,
  input  wire dpr_pkg::cfg_t   cfg_i,
  input  wire logic            fire_i,
  output dpr_pkg::result_t     result_o
);
  import dpr_pkg::*;

  logic [7:0]  lock_q   [CHANNELS];
  logic [7:0]  status_q [CHANNELS];
  logic [7:0]  mode_q   [CHANNELS];
  logic [15:0] live_q   [CHANNELS];
  logic [7:0]  byte_q   [CHANNELS][NumBytes];
  logic [15:0] word_q   [CHANNELS][NumWords];
  logic [7:0]  tool_q   [CHANNELS][NumTools];
  logic [15:0] rhold_q  [PORTS];
  logic [15:0] whold_q  [PORTS];

  logic [0:0]       ch;
  logic [PortW-1:0] pidx;
  logic             ch_ok, port_ok, range_bad;
  slot_t            slot;
  status_e          status;
  logic [7:0]       rdata;
  logic [7:0]       bv;
  logic             we_lock, we_mode, we_byte, we_word, we_tool, we_live, we_status;
  logic             we_rhold, we_whold;
  logic [15:0]      live_d, rhold_d, whold_d;
  logic [7:0]       mode_new, mode_eff;

  assign ch        = item_i.channel;
  assign pidx      = item_i.port[PortW-1:0];
  assign bv        = item_i.byte_value;
  assign ch_ok     = 32'(ch) < 32'(CHANNELS);
  assign port_ok   = 32'(item_i.port) < 32'(PORTS);
  assign range_bad = !port_ok || (item_i.bank_address > {3'b000, cfg_i.last_address})
                     || (item_i.bank_address > {3'b000, MaxAddr});
  assign slot      = dpr_slot(item_i.bank_address[4:0]);

  always_comb begin
    status    = ST_OK;
    rdata     = '0;
    we_lock   = 1'b0;
    we_mode   = 1'b0;
    we_byte   = 1'b0;
    we_word   = 1'b0;
    we_tool   = 1'b0;
    we_live   = 1'b0;
    we_status = 1'b0;
    we_rhold  = 1'b0;
    we_whold  = 1'b0;
    live_d    = item_i.word_value;
    rhold_d   = word_q[ch][slot.idx];
    whold_d   = {bv, 8'h00};
    if (!ch_ok) begin
      status = ST_RANGE;
    end else begin
      case (func_e'(item_i.func))
        FUNC_READ: begin
          if (range_bad) begin
            status = ST_RANGE;
          end else begin
            case (slot.kind)
              K_LAST:     rdata = {3'b000, cfg_i.last_address};
              K_LOCK:     rdata = lock_q[ch];
              K_ID:       rdata = cfg_i.bank_id;
              K_VER:      rdata = cfg_i.bank_version;
              K_STAT:     rdata = status_q[ch];
              K_MODE:     rdata = mode_q[ch];
              K_BYTE:     rdata = byte_q[ch][slot.idx];
              K_MSB: begin
                we_rhold = 1'b1;
                rdata    = rhold_d[15:8];
              end
              K_LSB:      rdata = rhold_q[pidx][7:0];
              K_TOOL:     rdata = tool_q[ch][slot.idx];
              K_LIVE_MSB: rdata = live_q[ch][15:8];
              K_LIVE_LSB: rdata = live_q[ch][7:0];
              default:    rdata = '0;
            endcase
          end
        end
        FUNC_WRITE: begin
          if (lock_q[ch] != LockOpen && item_i.bank_address != LockAddr) begin
            status = ST_DENY;
          end else if (range_bad) begin
            status = ST_RANGE;
          end else begin
            case (slot.kind)
              K_LOCK: we_lock = 1'b1;
              K_MODE: we_mode = 1'b1;
              K_BYTE: we_byte = 1'b1;
              K_TOOL: we_tool = 1'b1;
              K_MSB, K_LIVE_MSB: we_whold = 1'b1;
              K_LSB: begin
                whold_d  = whold_q[pidx] | {8'h00, bv};
                we_whold = 1'b1;
                we_word  = 1'b1;
              end
              K_LIVE_LSB: begin
                whold_d  = whold_q[pidx] | {8'h00, bv};
                we_whold = 1'b1;
                we_live  = 1'b1;
                live_d   = whold_d;
              end
              default: status = ST_RANGE;
            endcase
          end
        end
        FUNC_SET_STATUS: we_status = 1'b1;
        FUNC_SET_LIVE:   we_live   = 1'b1;
        FUNC_SET_MODE:   we_mode   = 1'b1;
        default:         status    = ST_RANGE;
      endcase
    end
    if (status != ST_OK) begin
      rdata = '0;
    end
  end

  assign mode_new = we_mode ? bv : mode_q[ch];
  assign mode_eff = ((mode_new & ModeLowMask) == 8'h00) ? (mode_new & ModeHighMask) : mode_new;

  assign result_o = '{read_data: rdata, access_status: status,
                      effective_mode: ch_ok ? mode_eff : 8'h00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        lock_q[c]   <= LockReset;
        status_q[c] <= '0;
        mode_q[c]   <= '0;
        live_q[c]   <= OnTimeReset;
        for (int b = 0; b < NumBytes; b++) byte_q[c][b] <= '0;
        for (int w = 0; w < NumWords; w++) word_q[c][w] <= '0;
        for (int t = 0; t < NumTools; t++) tool_q[c][t] <= '0;
      end
      for (int p = 0; p < PORTS; p++) begin
        rhold_q[p] <= '0;
        whold_q[p] <= '0;
      end
    end else if (fire_i) begin
      if (we_lock)   lock_q[ch]             <= bv;
      if (we_status) status_q[ch]           <= bv;
      if (we_mode)   mode_q[ch]             <= bv;
      if (we_live)   live_q[ch]             <= live_d;
      if (we_byte)   byte_q[ch][slot.idx]   <= bv;
      if (we_word)   word_q[ch][slot.idx]   <= whold_d;
      if (we_tool)   tool_q[ch][slot.idx]   <= bv;
      if (we_rhold)  rhold_q[pidx]          <= rhold_d;
      if (we_whold)  whold_q[pidx]          <= whold_d;
    end
  end
endmodule

`default_nettype wire

@@ rtl/dimming_profile_register_bank.sv @@
// Top level of the dimming profile register bank.
`timescale 1ns / 1ps
`default_nettype none

// The bank takes one item per clock cycle and returns exactly one result for each: the item
// is held in the input register, where the decode and the bank update happen, and its result
// is then captured in the result register. A stalled result holds the input register, so the
// sustained rate is one item per cycle whenever the result side takes every cycle. All bank
// and valid state has reset values, so no clearing pass follows reset. Register writes are
// always taken and are meant to arrive only while no item is in flight.
module dimming_profile_register_bank (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dpr_in_if.sink    in_i,
  dpr_out_if.source out_o,
  dpr_cfg_if.sink   cfg_i
);
  import dpr_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result;
  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  cfg_t    cfg_q, cfg_d;

  assign advance = item_valid && (!out_valid_q || out_o.ready);

  dpr_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item),
    .valid_o   (item_valid)
  );

  dpr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .fire_i   (advance),
    .result_o (result)
  );

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LAST_ADDRESS: cfg_d.last_address = cfg_i.data[4:0];
        CFG_BANK_ID:      cfg_d.bank_id      = cfg_i.data;
        CFG_BANK_VERSION: cfg_d.bank_version = cfg_i.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cfg_q       <= '{last_address: LastAddrReset, bank_id: BankIdReset,
                       bank_version: BankVerReset};
    end else begin
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = out_q.read_data;
  assign out_o.access_status  = out_q.access_status;
  assign out_o.effective_mode = out_q.effective_mode;
endmodule

`default_nettype wire

@@ rtl/dpr_checker.sv @@
// Port-level checks on the result channel of the register bank, with their bind.
`timescale 1ns / 1ps
`default_nettype none

module dpr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] read_data_i,
  input wire logic [1:0] access_status_i,
  input wire logic [7:0] effective_mode_i
);
  import dpr_pkg::*;

  // A failed access never returns data.
  a_no_data_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && access_status_i != ST_OK |-> read_data_i == 8'h00)
    else $error("read data returned with a failed access");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> access_status_i != 2'd3)
    else $error("undefined access status");

  // A mode with both low bits clear is reduced to its top two bits.
  a_mode_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && effective_mode_i[1:0] == 2'b00 |-> effective_mode_i[5:2] == 4'h0)
    else $error("effective mode not masked");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(read_data_i)
      && $stable(access_status_i) && $stable(effective_mode_i))
    else $error("result changed while stalled");
endmodule

bind dimming_profile_register_bank dpr_checker u_dpr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .read_data_i      (out_o.read_data),
  .access_status_i  (out_o.access_status),
  .effective_mode_i (out_o.effective_mode)
);

`default_nettype wire
